@@ hw/rtl/isrf_pkg.sv @@
// Package for the image spike removal filter: frame geometry, derived widths,
// sequencer state type and the control struct for the neighbour unit.
// No dependencies.
package isrf_pkg;

    localparam int FRAME_WIDTH  = 16;
    localparam int FRAME_HEIGHT = 16;

    localparam int PIX_W = 4;
    localparam int COL_W = $clog2(FRAME_WIDTH);
    localparam int ROW_W = $clog2(FRAME_HEIGHT);
    localparam int SUM_W = 6;
    localparam int CNT_W = 3;

    localparam logic [PIX_W-1:0] MARGIN_RESET = PIX_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CTR,
        ST_LEFT,
        ST_RIGHT,
        ST_BELOW,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic             clear;
        logic             feed;
        logic             have;
        logic [PIX_W-1:0] nb;
        logic [PIX_W-1:0] center;
    } t_nb_ctrl;

endpackage

@@ hw/rtl/image_spike_removal_filter.sv @@
// Top level of the image spike removal filter (4-neighbour mean).
// Holds the sequencer, counters and output register; uses isrf_pkg,
// isrf_line_ram and isrf_nb_unit.
//
//  Channel   Direction  Handshake                         Payload
//  pixel     in         i_pixel_valid / o_pixel_ready     i_pixel
//  result    out        o_result_valid / i_result_ready   o_filtered_pixel,
//                                                         o_last_in_run, o_end_of_frame
//  config    in         i_spike_margin_we (no wait)       i_spike_margin
//
// A row-0 pixel is written to the middle line store at acceptance and ready
// stays high. A pixel of a later row is accepted, then passes six sequencer
// steps (read both line stores, read the right neighbour, then one neighbour
// per cycle through the shared unit, emit) with ready low. The bottom-right
// pixel adds a flush of the last row, one pass of those steps per column.
// Reset is synchronous, active low; it clears control state and sets the margin
// to 1. Line store contents are undefined until written. The emit step waits
// while the output register holds a request the sink has not taken.
module image_spike_removal_filter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_pixel_valid,
    output logic                       o_pixel_ready,
    input  logic [isrf_pkg::PIX_W-1:0] i_pixel,
    output logic                       o_result_valid,
    input  logic                       i_result_ready,
    output logic [isrf_pkg::PIX_W-1:0] o_filtered_pixel,
    output logic                       o_last_in_run,
    output logic                       o_end_of_frame,
    input  logic                       i_spike_margin_we,
    input  logic [isrf_pkg::PIX_W-1:0] i_spike_margin
);

    localparam logic [isrf_pkg::COL_W-1:0] COL_LAST = isrf_pkg::COL_W'(isrf_pkg::FRAME_WIDTH - 1);
    localparam logic [isrf_pkg::ROW_W-1:0] ROW_LAST = isrf_pkg::ROW_W'(isrf_pkg::FRAME_HEIGHT - 1);

    isrf_pkg::t_state r_state, n_state;

    logic [isrf_pkg::COL_W-1:0] r_col, n_col;
    logic [isrf_pkg::ROW_W-1:0] r_row, n_row;
    logic                       r_flush, n_flush;
    logic [isrf_pkg::PIX_W-1:0] r_left, n_left;
    logic [isrf_pkg::PIX_W-1:0] r_pix, n_pix;
    logic [isrf_pkg::PIX_W-1:0] r_center, n_center;
    logic [isrf_pkg::PIX_W-1:0] r_margin;

    logic                       r_out_valid, n_out_valid;
    logic [isrf_pkg::PIX_W-1:0] r_out_pix, n_out_pix;
    logic                       r_out_last, n_out_last;
    logic                       r_out_eof, n_out_eof;

    // Line store ports
    logic                       w_up_we, w_up_re;
    logic [isrf_pkg::COL_W-1:0] w_up_raddr;
    logic [isrf_pkg::PIX_W-1:0] w_up_rdata;
    logic                       w_mid_we, w_mid_re;
    logic [isrf_pkg::COL_W-1:0] w_mid_waddr, w_mid_raddr;
    logic [isrf_pkg::PIX_W-1:0] w_mid_wdata, w_mid_rdata;

    isrf_pkg::t_nb_ctrl         w_ctrl;
    logic [isrf_pkg::PIX_W-1:0] w_filt;

    logic w_accept;
    logic w_col_last;
    logic w_emit_go;
    logic [isrf_pkg::COL_W-1:0] w_right_addr;

    assign w_accept     = i_pixel_valid && o_pixel_ready;
    assign w_col_last   = (r_col == COL_LAST);
    assign w_emit_go    = !r_out_valid || i_result_ready;
    assign w_right_addr = w_col_last ? '0 : r_col + isrf_pkg::COL_W'(1);

    // Upper store: filtered values of the row above; middle: original values.
    isrf_line_ram u_upper (
        .i_clk   (i_clk),
        .i_we    (w_up_we),
        .i_waddr (r_col),
        .i_wdata (w_filt),
        .i_re    (w_up_re),
        .i_raddr (w_up_raddr),
        .o_rdata (w_up_rdata)
    );

    isrf_line_ram u_middle (
        .i_clk   (i_clk),
        .i_we    (w_mid_we),
        .i_waddr (w_mid_waddr),
        .i_wdata (w_mid_wdata),
        .i_re    (w_mid_re),
        .i_raddr (w_mid_raddr),
        .o_rdata (w_mid_rdata)
    );

    isrf_nb_unit u_nb (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_margin (r_margin),
        .o_result (w_filt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= isrf_pkg::ST_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_flush     <= 1'b0;
            r_left      <= '0;
            r_margin    <= isrf_pkg::MARGIN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_flush     <= n_flush;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
            if (i_spike_margin_we) begin
                r_margin <= i_spike_margin;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_pix      <= n_pix;
        r_center   <= n_center;
        r_out_pix  <= n_out_pix;
        r_out_last <= n_out_last;
        r_out_eof  <= n_out_eof;
    end

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_flush     = r_flush;
        n_left      = r_left;
        n_pix       = r_pix;
        n_center    = r_center;
        n_out_valid = r_out_valid;
        n_out_pix   = r_out_pix;
        n_out_last  = r_out_last;
        n_out_eof   = r_out_eof;

        o_pixel_ready = 1'b0;

        w_up_we     = 1'b0;
        w_up_re     = 1'b0;
        w_up_raddr  = r_col;
        w_mid_we    = 1'b0;
        w_mid_waddr = r_col;
        w_mid_wdata = r_pix;
        w_mid_re    = 1'b0;
        w_mid_raddr = r_col;

        w_ctrl.clear  = 1'b0;
        w_ctrl.feed   = 1'b0;
        w_ctrl.have   = 1'b0;
        w_ctrl.nb     = r_left;
        w_ctrl.center = r_center;

        // Drop the request once the sink takes it.
        if (r_out_valid && i_result_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            isrf_pkg::ST_IDLE: begin
                o_pixel_ready = 1'b1;
                if (w_accept) begin
                    n_pix = i_pixel;
                    if (r_row == '0) begin
                        // First row only fills the middle store.
                        w_mid_we    = 1'b1;
                        w_mid_wdata = i_pixel;
                        n_col       = w_col_last ? '0 : r_col + isrf_pkg::COL_W'(1);
                        if (w_col_last) begin
                            n_row = r_row + isrf_pkg::ROW_W'(1);
                        end
                    end else begin
                        n_state = isrf_pkg::ST_READ;
                    end
                end
            end
            isrf_pkg::ST_READ: begin
                // Fetch upper and center; clear the unit.
                w_up_re      = 1'b1;
                w_mid_re     = 1'b1;
                w_ctrl.clear = 1'b1;
                n_state      = isrf_pkg::ST_CTR;
            end
            isrf_pkg::ST_CTR: begin
                // Hold center, fetch right neighbour, feed upper.
                n_center      = w_mid_rdata;
                w_mid_re      = 1'b1;
                w_mid_raddr   = w_right_addr;
                w_ctrl.center = w_mid_rdata;
                w_ctrl.feed   = 1'b1;
                w_ctrl.have   = r_flush || (r_row > isrf_pkg::ROW_W'(1));
                w_ctrl.nb     = w_up_rdata;
                n_state       = isrf_pkg::ST_LEFT;
            end
            isrf_pkg::ST_LEFT: begin
                w_ctrl.feed = 1'b1;
                w_ctrl.have = (r_col != '0);
                w_ctrl.nb   = r_left;
                n_state     = isrf_pkg::ST_RIGHT;
            end
            isrf_pkg::ST_RIGHT: begin
                w_ctrl.feed = 1'b1;
                w_ctrl.have = !w_col_last;
                w_ctrl.nb   = w_mid_rdata;
                n_state     = isrf_pkg::ST_BELOW;
            end
            isrf_pkg::ST_BELOW: begin
                // Lower neighbour is the incoming pixel; none during flush.
                w_ctrl.feed = 1'b1;
                w_ctrl.have = !r_flush;
                w_ctrl.nb   = r_pix;
                n_state     = isrf_pkg::ST_EMIT;
            end
            isrf_pkg::ST_EMIT: begin
                if (w_emit_go) begin
                    w_up_we     = 1'b1;
                    n_left      = w_filt;
                    n_out_valid = 1'b1;
                    n_out_pix   = w_filt;
                    if (r_flush) begin
                        n_out_last = w_col_last;
                        n_out_eof  = w_col_last;
                        if (w_col_last) begin
                            // Frame done: restart positions.
                            n_col   = '0;
                            n_row   = '0;
                            n_flush = 1'b0;
                            n_state = isrf_pkg::ST_IDLE;
                        end else begin
                            n_col   = r_col + isrf_pkg::COL_W'(1);
                            n_state = isrf_pkg::ST_READ;
                        end
                    end else begin
                        w_mid_we   = 1'b1;
                        n_out_eof  = 1'b0;
                        n_out_last = !(w_col_last && (r_row == ROW_LAST));
                        n_col      = w_col_last ? '0 : r_col + isrf_pkg::COL_W'(1);
                        if (w_col_last && (r_row == ROW_LAST)) begin
                            // Bottom-right pixel: flush the last row.
                            n_flush = 1'b1;
                            n_state = isrf_pkg::ST_READ;
                        end else begin
                            if (w_col_last) begin
                                n_row = r_row + isrf_pkg::ROW_W'(1);
                            end
                            n_state = isrf_pkg::ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = isrf_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_result_valid   = r_out_valid;
    assign o_filtered_pixel = r_out_pix;
    assign o_last_in_run    = r_out_last;
    assign o_end_of_frame   = r_out_eof;

endmodule

@@ hw/rtl/isrf_line_ram.sv @@
// Line store for the spike filter: one row of pixels, one write and one
// registered read port. Depends on isrf_pkg.
module isrf_line_ram (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [isrf_pkg::COL_W-1:0] i_waddr,
    input  logic [isrf_pkg::PIX_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [isrf_pkg::COL_W-1:0] i_raddr,
    output logic [isrf_pkg::PIX_W-1:0] o_rdata
);

    logic [isrf_pkg::PIX_W-1:0] r_mem [isrf_pkg::FRAME_WIDTH];
    logic [isrf_pkg::PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/isrf_nb_unit.sv @@
// Shared neighbour unit: takes one neighbour a cycle, accumulates sum, count
// and the spike flag, and gives the filtered value. Depends on isrf_pkg.
module isrf_nb_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  isrf_pkg::t_nb_ctrl         i_ctrl,
    input  logic [isrf_pkg::PIX_W-1:0] i_margin,
    output logic [isrf_pkg::PIX_W-1:0] o_result
);

    logic [isrf_pkg::SUM_W-1:0] r_sum;
    logic [isrf_pkg::CNT_W-1:0] r_cnt;
    logic                       r_spike;
    logic                       w_over;
    logic [11:0]                w_third;
    logic [isrf_pkg::PIX_W-1:0] w_mean;

    // Spike test: center above neighbour by more than the margin.
    assign w_over = (i_ctrl.center > i_ctrl.nb) &&
                    ((i_ctrl.center - i_ctrl.nb) > i_margin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_cnt   <= '0;
            r_spike <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_sum   <= '0;
            r_cnt   <= '0;
            r_spike <= 1'b0;
        end else if (i_ctrl.feed && i_ctrl.have) begin
            r_sum   <= r_sum + {{(isrf_pkg::SUM_W-isrf_pkg::PIX_W){1'b0}}, i_ctrl.nb};
            r_cnt   <= r_cnt + isrf_pkg::CNT_W'(1);
            r_spike <= r_spike | w_over;
        end
    end

    // Divide by three as multiply by 43/128, exact for sums up to 63.
    assign w_third = {6'd0, r_sum} * 12'd43;

    always_comb begin
        case (r_cnt)
            3'd2:    w_mean = r_sum[isrf_pkg::PIX_W:1];
            3'd3:    w_mean = w_third[10:7];
            3'd4:    w_mean = r_sum[isrf_pkg::PIX_W+1:2];
            default: w_mean = r_sum[isrf_pkg::PIX_W-1:0];
        endcase
    end

    assign o_result = (r_spike && (r_cnt != '0)) ? w_mean : i_ctrl.center;

endmodule

@@ hw/rtl/isrf_checker.sv @@
// Port-level checks on the result channel of the spike filter, and the bind
// that attaches them to the top level. Depends on the top level's ports only.
module isrf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_result_valid,
    input logic       i_result_ready,
    input logic [3:0] o_filtered_pixel,
    input logic       o_last_in_run,
    input logic       o_end_of_frame
);

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !i_result_ready |=> o_result_valid)
        else $error("result request dropped before taken");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !i_result_ready |=>
            $stable(o_filtered_pixel) && $stable(o_last_in_run) && $stable(o_end_of_frame))
        else $error("stalled result changed");

    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_end_of_frame |-> o_last_in_run)
        else $error("end of frame without last in run");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid)
        else $error("result request after reset");

endmodule

bind image_spike_removal_filter isrf_checker u_isrf_checker (.*);
